// File: rtl/vcp_pkg.sv
package vcp_pkg;

    // video memory, indexed by the low bits of the access address (power of two depth)
    localparam int VRAM_DEPTH = 16384;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam int ADDR_W     = 14;
    localparam int LINE_W     = 9;

    localparam logic [LINE_W-1:0] VBLANK_LINE = LINE_W'(192);

    // processor access kinds carried on the input user field
    typedef enum logic [2:0] {
        MODE_DATA_WRITE = 3'd0,
        MODE_DATA_READ  = 3'd1,
        MODE_CTRL_WRITE = 3'd2,
        MODE_STAT_READ  = 3'd3,
        MODE_TICK       = 3'd4
    } t_mode;

    // screen modes
    typedef enum logic [1:0] {
        SCR_TEXT = 2'd0,
        SCR_G1   = 2'd1,
        SCR_G2   = 2'd2,
        SCR_MC   = 2'd3
    } t_screen;

    // top two bits of the second control byte that select a register write
    localparam logic [1:0] CTL_REG_WRITE = 2'b10;

    // status and register 1 bit positions
    localparam int ST_VBLANK_BIT = 7;
    localparam logic [7:0] ST_KEEP = 8'h1F;
    localparam int R1_IE_BIT    = 5;
    localparam int R1_BLANK_BIT = 6;
    localparam int R1_SIZE_BIT  = 1;
    localparam int R1_MAG_BIT   = 0;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

endpackage

// File: rtl/vcp_ram.sv
module vcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/video_chip_cpu_port.sv
// a result word is registered and appears in the cycle after its input word is accepted
// throughput: one word per cycle; input ready drops only while a result is stalled
// the read-ahead refetch uses the single registered read port of the video memory
// reset: synchronous, active low; clears address, latch, status, registers and
// output valid; screen mode returns to graphics one; video memory is not cleared
module video_chip_cpu_port
    import vcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] data_byte, [16:8] scanline, [23:17] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] read_data, [8] irq_line, [10:9] screen_mode, [11] display_enable,
    // [12] sprite_size_16, [13] sprite_magnify, [15:14] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // processor-visible state
    logic [ADDR_W-1:0] r_addr,       n_addr;
    logic [7:0]        r_read_ahead, n_read_ahead;
    logic              r_ra_ram,     n_ra_ram;     // read-ahead lives in the ram output
    logic [7:0]        r_latch,      n_latch;
    logic              r_first,      n_first;      // next control byte is the first one
    logic [7:0]        r_status,     n_status;
    logic              r_irq,        n_irq;
    logic [7:0]        r_reg0,       n_reg0;       // registers 2-7 only hold table bases
    logic [7:0]        r_reg1,       n_reg1;
    t_screen           r_scr,        n_scr;

    // output word register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic              accept;
    t_mode             in_mode;
    logic [7:0]        in_byte;
    logic [LINE_W-1:0] in_line;
    logic [7:0]        rd;
    logic [7:0]        ra_now;

    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_q;

    // screen mode from M1 (reg1 bit 4), M2 (reg1 bit 3) and M3 (reg0 bit 1)
    function automatic t_screen decode_screen(logic [7:0] reg0, logic [7:0] reg1,
                                              t_screen prev);
        t_screen s;
        s = prev;
        case ({reg1[4], reg1[3], reg0[1]})
            3'b000:  s = SCR_G1;
            3'b001:  s = SCR_G2;
            3'b010:  s = SCR_MC;
            3'b100:  s = SCR_TEXT;
            default: s = prev;    // conflicting mode bits keep the old mode
        endcase
        return s;
    endfunction

    assign accept        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_mode       = t_mode'(s_axis_tuser);
    assign in_byte       = s_axis_tdata[7:0];
    assign in_line       = s_axis_tdata[16:8];
    assign ra_now        = r_ra_ram ? ram_q : r_read_ahead;

    always_comb begin
        n_addr       = r_addr;
        n_read_ahead = r_read_ahead;
        n_ra_ram     = r_ra_ram;
        n_latch      = r_latch;
        n_first      = r_first;
        n_status     = r_status;
        n_irq        = r_irq;
        n_reg0       = r_reg0;
        n_reg1       = r_reg1;
        n_scr        = r_scr;
        rd           = 8'h00;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_addr;

        case (in_mode)
            MODE_DATA_WRITE: begin
                ram_we       = accept;
                n_read_ahead = in_byte;
                n_ra_ram     = 1'b0;
                n_addr       = r_addr + ADDR_W'(1);
                n_first      = 1'b1;
            end
            MODE_DATA_READ: begin
                rd        = ra_now;
                n_addr    = r_addr + ADDR_W'(1);
                ram_re    = accept;
                ram_raddr = n_addr;
                n_ra_ram  = 1'b1;
                n_first   = 1'b1;
            end
            MODE_CTRL_WRITE: begin
                if (r_first) begin
                    n_latch = in_byte;
                    n_addr  = {r_addr[ADDR_W-1:8], in_byte};
                    n_first = 1'b0;
                end else begin
                    n_first = 1'b1;
                    n_addr  = {in_byte[5:0], r_addr[7:0]};
                    if (!in_byte[7]) begin
                        // address setup with read-ahead fill
                        ram_re    = accept;
                        ram_raddr = n_addr;
                        n_ra_ram  = 1'b1;
                    end else if (in_byte[7:6] == CTL_REG_WRITE && !in_byte[3]) begin
                        if (in_byte[2:0] == 3'd0) begin
                            n_reg0 = r_latch;
                            n_scr  = decode_screen(r_latch, r_reg1, r_scr);
                        end else if (in_byte[2:0] == 3'd1) begin
                            n_reg1 = r_latch;
                            n_scr  = decode_screen(r_reg0, r_latch, r_scr);
                            if (r_latch[R1_IE_BIT] && r_status[ST_VBLANK_BIT]) begin
                                n_irq = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_STAT_READ: begin
                rd       = r_status;
                n_status = r_status & ST_KEEP;
                n_first  = 1'b1;
                n_irq    = 1'b0;
            end
            MODE_TICK: begin
                if (in_line == VBLANK_LINE) begin
                    n_status[ST_VBLANK_BIT] = 1'b1;
                    if (r_reg1[R1_IE_BIT]) begin
                        n_irq = 1'b1;
                    end
                end
            end
            default: begin
                // unused access kinds leave everything untouched
            end
        endcase

        n_out_data = {2'b00, n_reg1[R1_MAG_BIT], n_reg1[R1_SIZE_BIT],
                      n_reg1[R1_BLANK_BIT], n_scr, n_irq, rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_read_ahead <= 8'h00;
            r_ra_ram     <= 1'b0;
            r_latch      <= 8'h00;
            r_first      <= 1'b1;
            r_status     <= 8'h00;
            r_irq        <= 1'b0;
            r_reg0       <= 8'h00;
            r_reg1       <= 8'h00;
            r_scr        <= SCR_G1;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_addr       <= n_addr;
                r_read_ahead <= n_read_ahead;
                r_ra_ram     <= n_ra_ram;
                r_latch      <= n_latch;
                r_first      <= n_first;
                r_status     <= n_status;
                r_irq        <= n_irq;
                r_reg0       <= n_reg0;
                r_reg1       <= n_reg1;
                r_scr        <= n_scr;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    // smaller memories mirror through the low address bits
    vcp_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr[VRAM_AW-1:0]),
        .i_wdata (in_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr[VRAM_AW-1:0]),
        .o_rdata (ram_q)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: rtl/vcp_checker.sv
module vcp_checker
    import vcp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [2:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // every accepted word gives a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> m_axis_tvalid)
        else $error("result missing after accept");

    // a status read always drops the interrupt line
    a_stat_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser == MODE_STAT_READ |=> !m_axis_tdata[8])
        else $error("interrupt still high after status read");

    // writes return no read data
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (s_axis_tuser == MODE_DATA_WRITE || s_axis_tuser == MODE_CTRL_WRITE)
        |=> m_axis_tdata[7:0] == 8'h00)
        else $error("read data on a write");

endmodule

bind video_chip_cpu_port vcp_checker u_vcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/cpu_port_sb_pkg.sv
package cpu_port_sb_pkg;

    import vcp_pkg::*;

    // result word, lowest field last
    typedef struct packed {
        logic [1:0] pad;
        logic       magnify;
        logic       size16;
        logic       disp_en;
        t_screen    screen;
        logic       irq;
        logic [7:0] rd;
    } port_result_t;

    // second control byte codes besides the register write
    localparam logic [1:0] CTL_READ_SETUP  = 2'b00;
    localparam logic [1:0] CTL_WRITE_SETUP = 2'b01;
    localparam logic [1:0] CTL_ADDR_ONLY   = 2'b11;

    class port_scoreboard;

        logic [7:0]        vram [VRAM_DEPTH];
        bit                written [VRAM_DEPTH];
        logic [ADDR_W-1:0] written_addrs [$];

        logic [ADDR_W-1:0] access_addr;
        logic [7:0]        read_ahead;
        logic [7:0]        latched;
        logic [7:0]        status;
        logic [7:0]        regs [8];
        bit                first_byte;
        bit                irq;
        t_screen           screen;

        port_result_t      pending_results [$];
        int                errors;

        function new();
            access_addr = '0;
            read_ahead  = '0;
            latched     = '0;
            status      = '0;
            first_byte  = 1'b1;
            irq         = 1'b0;
            screen      = SCR_G1;
            errors      = 0;
            foreach (regs[i]) regs[i] = '0;
        endfunction

        function int vram_index(logic [ADDR_W-1:0] a);
            return int'(a) % VRAM_DEPTH;
        endfunction

        // true when the word would fetch a memory byte never stored
        function bit fetches_unwritten(logic [2:0] op, logic [7:0] data);
            logic [ADDR_W-1:0] target;
            if (op == MODE_DATA_READ) begin
                target = access_addr + 1'b1;
                return !written[vram_index(target)];
            end
            if (op == MODE_CTRL_WRITE && !first_byte &&
                data[7:6] != CTL_REG_WRITE && data[7:6] != CTL_ADDR_ONLY) begin
                target = {data[5:0], access_addr[7:0]};
                return !written[vram_index(target)];
            end
            return 1'b0;
        endfunction

        function void redecode_screen();
            logic [2:0] sel;
            sel = {regs[1][4], regs[1][3], regs[0][1]};
            case (sel)
                3'd0: screen = SCR_G1;
                3'd1: screen = SCR_G2;
                3'd2: screen = SCR_MC;
                3'd4: screen = SCR_TEXT;
                default: ;
            endcase
        endfunction

        function void control_byte(logic [7:0] b);
            int r;
            if (first_byte) begin
                latched     = b;
                access_addr = {access_addr[13:8], b};
                first_byte  = 1'b0;
                return;
            end
            first_byte  = 1'b1;
            access_addr = {b[5:0], access_addr[7:0]};
            case (b[7:6])
                CTL_READ_SETUP, CTL_WRITE_SETUP:
                    read_ahead = vram[vram_index(access_addr)];
                CTL_REG_WRITE: begin
                    r = int'(b[3:0]);
                    if (r < 8) begin
                        regs[r] = latched;
                        if (r == 1 && latched[R1_IE_BIT] && status[ST_VBLANK_BIT])
                            irq = 1'b1;
                        if (r <= 1)
                            redecode_screen();
                    end
                end
                default: ;
            endcase
        endfunction

        // works out the result of one accepted word and queues it
        function void note_word(logic [2:0] op, logic [7:0] data, logic [LINE_W-1:0] line);
            port_result_t res;
            logic [7:0]   rd;
            int           idx;
            rd = '0;
            case (op)
                MODE_DATA_WRITE: begin
                    idx = vram_index(access_addr);
                    if (!written[idx])
                        written_addrs.push_back(access_addr);
                    vram[idx]    = data;
                    written[idx] = 1'b1;
                    read_ahead   = data;
                    access_addr  = access_addr + 1'b1;
                    first_byte   = 1'b1;
                end
                MODE_DATA_READ: begin
                    rd          = read_ahead;
                    access_addr = access_addr + 1'b1;
                    read_ahead  = vram[vram_index(access_addr)];
                    first_byte  = 1'b1;
                end
                MODE_CTRL_WRITE: control_byte(data);
                MODE_STAT_READ: begin
                    rd         = status;
                    status     = status & ST_KEEP;
                    first_byte = 1'b1;
                    irq        = 1'b0;
                end
                MODE_TICK: begin
                    if (line == VBLANK_LINE) begin
                        status[ST_VBLANK_BIT] = 1'b1;
                        if (regs[1][R1_IE_BIT])
                            irq = 1'b1;
                    end
                end
                default: ;
            endcase
            res.pad     = '0;
            res.magnify = regs[1][R1_MAG_BIT];
            res.size16  = regs[1][R1_SIZE_BIT];
            res.disp_en = regs[1][R1_BLANK_BIT];
            res.screen  = screen;
            res.irq     = irq;
            res.rd      = rd;
            pending_results.push_back(res);
        endfunction

        // four-state compare so that unknown bits count as a mismatch
        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_word(port_result_t got);
            port_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result word %0h with nothing expected", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("read_data", want.rd, got.rd);
            compare_field("irq_line", want.irq, got.irq);
            compare_field("screen_mode", want.screen, got.screen);
            compare_field("display_enable", want.disp_en, got.disp_en);
            compare_field("sprite_size_16", want.size16, got.size16);
            compare_field("sprite_magnify", want.magnify, got.magnify);
            compare_field("padding", want.pad, got.pad);
        endfunction

    endclass

endpackage

// File: dv/tb_video_chip_cpu_port.sv
module tb_video_chip_cpu_port;

    import vcp_pkg::*;
    import cpu_port_sb_pkg::*;

    // words to send in total and quiet cycles tolerated before giving up
    localparam int ITEM_TARGET = 600;
    localparam int STALL_LIMIT = 1000;
    localparam int LAST_LINE   = 261;

    // user codes the block must ignore
    localparam logic [2:0] MODE_RESERVED_LO = 3'd5;
    localparam logic [2:0] MODE_RESERVED_HI = 3'd7;

    // receiver stall patterns
    localparam int RX_FREE   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SLOW   = 2;
    localparam int RX_TOGGLE = 3;
    localparam int RX_HOLD   = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] data_byte, [16:8] scanline, [23:17] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [2:0] mode
    logic [2:0]            s_axis_tuser = MODE_STAT_READ;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] read_data, [8] irq_line, [10:9] screen_mode, [11] display_enable,
    // [12] sprite_size_16, [13] sprite_magnify, [15:14] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    port_scoreboard sb;
    int             words_sent = 0;
    int             burst_left = 0;
    bit             long_hold_done = 1'b0;

    video_chip_cpu_port DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [LINE_W-1:0] rand_line();
        return LINE_W'($urandom_range(0, LAST_LINE));
    endfunction

    // high address bits: mostly a few low pages so reads find stored bytes,
    // sometimes the top page to exercise the wrap, sometimes any page
    function automatic logic [5:0] pick_high_bits();
        case ($urandom_range(0, 7))
            0:       return 6'h3F;
            1:       return 6'($urandom);
            default: return 6'($urandom_range(0, 3));
        endcase
    endfunction

    // offers one word in a sender burst, waits for the handshake and
    // notes it with the scoreboard; any word that would fetch a byte never
    // stored is bent into a harmless one first
    task automatic send_access(input logic [2:0] op, input logic [7:0] data,
                               input logic [LINE_W-1:0] line);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        if (sb.fetches_unwritten(op, data)) begin
            if (op == MODE_DATA_READ)
                op = MODE_DATA_WRITE;
            else
                data[7:6] = CTL_ADDR_ONLY;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, line, data};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(op, data, line);
        words_sent++;
        burst_left--;
    endtask

    task automatic send_ctrl_pair(input logic [7:0] first, input logic [7:0] second);
        send_access(MODE_CTRL_WRITE, first, rand_line());
        send_access(MODE_CTRL_WRITE, second, rand_line());
    endtask

    // stop offering until every queued result word has come back
    task automatic wait_for_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: check every accepted word at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(port_result_t'(m_axis_tdata));
    end

    // receiver: stretches of different stall patterns, one long hold
    // once the traffic is going so the block backs up into its input
    initial begin : receiver
        int style;
        int span;
        wait (i_rst_n);
        forever begin
            style = $urandom_range(RX_FREE, RX_TOGGLE);
            span  = $urandom_range(10, 150);
            if (!long_hold_done && words_sent >= 200) begin
                style = RX_HOLD;
                span  = 120;
                long_hold_done = 1'b1;
            end
            repeat (span) begin
                @(negedge i_clk);
                case (style)
                    RX_FREE:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SLOW:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                    RX_TOGGLE: m_axis_tready <= ~m_axis_tready;
                    default:   m_axis_tready <= 1'b0;
                endcase
            end
        end
    end

    // watchdog: gives up after a long run of cycles with no word moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int                n;
        bit                drain_done;
        logic [ADDR_W-1:0] a;
        sb = new();
        drain_done = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // status after reset, ticks at both line extremes, then vblank with
        // interrupts off
        send_access(MODE_STAT_READ, 8'h00, 9'd0);
        send_access(MODE_TICK, 8'hFF, 9'd0);
        send_access(MODE_TICK, 8'h00, 9'(LAST_LINE));
        send_access(MODE_TICK, 8'h00, VBLANK_LINE);
        // a tick between the two control bytes must not reset the latch;
        // enabling interrupts with vblank already flagged raises the line
        send_access(MODE_CTRL_WRITE, 8'h20, 9'd0);
        send_access(MODE_TICK, 8'h00, 9'd100);
        send_access(MODE_CTRL_WRITE, {CTL_REG_WRITE, 6'd1}, 9'd0);
        // status read returns vblank, clears it and drops the line
        send_access(MODE_STAT_READ, 8'h00, 9'd0);
        // screen mode decode: valid combinations select their mode, meaningless ones keep the old mode
        send_ctrl_pair(8'hFF, {CTL_REG_WRITE, 6'd1});
        send_ctrl_pair(8'h02, {CTL_REG_WRITE, 6'd0});
        send_ctrl_pair(8'h00, {CTL_REG_WRITE, 6'd1});
        send_ctrl_pair(8'h10, {CTL_REG_WRITE, 6'd1});
        send_ctrl_pair(8'h00, {CTL_REG_WRITE, 6'd0});
        send_ctrl_pair(8'h08, {CTL_REG_WRITE, 6'd1});
        // register number above seven is ignored
        send_ctrl_pair(8'h55, {CTL_REG_WRITE, 6'h0F});
        // address wrap from the top of memory to zero
        send_ctrl_pair(8'hFF, {CTL_ADDR_ONLY, 6'h3F});
        send_access(MODE_DATA_WRITE, 8'h00, 9'd0);
        send_access(MODE_DATA_WRITE, 8'hFF, 9'd0);
        send_ctrl_pair(8'hFF, {CTL_READ_SETUP, 6'h3F});
        send_access(MODE_DATA_READ, 8'h00, 9'd0);
        // reserved user codes
        send_access(MODE_RESERVED_LO, 8'hA5, 9'd0);
        send_access(MODE_RESERVED_HI, 8'h5A, 9'(LAST_LINE));
        wait_for_drain();

        // random part: mostly address setups followed by runs of data words,
        // with register writes, status reads, ticks, noise and half-finished
        // control sequences in between
        while (words_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    send_ctrl_pair(8'($urandom), {2'($urandom), pick_high_bits()});
                    n = $urandom_range(1, 12);
                    repeat (n) send_access(MODE_DATA_WRITE, 8'($urandom), rand_line());
                end
                3, 4: begin
                    if (sb.written_addrs.size() != 0) begin
                        a = sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)];
                        send_ctrl_pair(a[7:0], {($urandom_range(0, 1) ? CTL_READ_SETUP :
                                                 CTL_WRITE_SETUP), a[13:8]});
                        n = $urandom_range(1, 8);
                        repeat (n) send_access(MODE_DATA_READ, 8'($urandom), rand_line());
                    end
                end
                5: send_ctrl_pair(8'($urandom),
                                  {CTL_REG_WRITE, 2'($urandom), 4'($urandom_range(0, 15))});
                6: begin
                    if ($urandom_range(0, 1))
                        send_access(MODE_STAT_READ, 8'($urandom), rand_line());
                    else
                        send_access(MODE_TICK, 8'($urandom),
                                    $urandom_range(0, 1) ? VBLANK_LINE : rand_line());
                end
                7, 8: send_access(3'($urandom_range(MODE_DATA_WRITE, MODE_RESERVED_HI)),
                                  8'($urandom), rand_line());
                default: begin
                    // first control byte, mostly cut short by another access
                    send_access(MODE_CTRL_WRITE, 8'($urandom), rand_line());
                    send_access(3'($urandom_range(MODE_DATA_WRITE, MODE_STAT_READ)),
                                8'($urandom), rand_line());
                    send_access(MODE_CTRL_WRITE, 8'($urandom), rand_line());
                end
            endcase
            if (!drain_done && words_sent >= 350) begin
                wait_for_drain();
                drain_done = 1'b1;
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        // wait on for stray result words
        repeat (4) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            $display("%0t: %0d result words never arrived", $time, sb.pending_results.size());
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
